@@ design/rsenc_pkg.sv @@
package rsenc_pkg;

  localparam int GF_W       = 6;
  localparam int PARITY_LEN = 21;
  localparam int GEN_LEN    = PARITY_LEN + 1;
  localparam int MSG_LEN    = 42;
  localparam int FLUSH_W    = $clog2(PARITY_LEN);

  typedef logic [GF_W-1:0] sym_t;

  // field polynomial x^6 + x + 1, low bits of the reduction term
  localparam sym_t POLY_LOW = 6'h03;

  // generator coefficients, lowest degree first
  localparam sym_t GEN [GEN_LEN] = '{
    6'd58, 6'd62, 6'd59, 6'd7,  6'd35, 6'd58, 6'd63, 6'd47, 6'd51, 6'd6,  6'd33,
    6'd43, 6'd44, 6'd27, 6'd7,  6'd53, 6'd39, 6'd62, 6'd52, 6'd41, 6'd44, 6'd1
  };

  typedef struct packed {
    sym_t sym;
    logic last;
  } out_item_t;

  function automatic sym_t gf_mul(sym_t a, sym_t b);
    sym_t acc;
    sym_t x;
    acc = '0;
    x   = a;
    for (int i = 0; i < GF_W; i++) begin
      if (b[i]) acc = acc ^ x;
      x = {x[GF_W-2:0], 1'b0} ^ (x[GF_W-1] ? POLY_LOW : sym_t'(0));
    end
    return acc;
  endfunction

endpackage

@@ design/rs_nonsystematic_encoder_gf64.sv @@
// Non-systematic RS encoder over GF(64) (x^6+x+1): codeword = message * degree-21
// generator, both lowest coefficient first. Each accepted message symbol yields one
// codeword symbol, and one symbol can be taken per cycle while the output queue is
// not full. After the MsgLen-th symbol of a block the 21 pending coefficients are
// shifted out of the cell chain, one per cycle unless the queue is full, with
// input stalled meanwhile; the last one carries block_end.
// Results sit in a two-entry output queue, so input keeps flowing while one waits.
module rs_nonsystematic_encoder_gf64 #(
  parameter int MsgLen = rsenc_pkg::MSG_LEN
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rsenc_pkg::sym_t msg_symbol_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rsenc_pkg::sym_t code_symbol_o,
  output logic            block_end_o
);
  import rsenc_pkg::*;

  localparam int CntW = (MsgLen > 1) ? $clog2(MsgLen) : 1;

  logic               accept, flush_step, shift_en, full, last_in, last_flush;
  logic [CntW-1:0]    cnt_q;
  logic               flush_q;
  logic [FLUSH_W-1:0] fcnt_q;
  sym_t               msg_eff;
  sym_t               sum [PARITY_LEN];
  out_item_t          push_item, out_item;

  assign in_stall_o = flush_q || full;
  assign accept     = in_valid_i && !in_stall_o;
  assign flush_step = flush_q && !full;
  assign shift_en   = accept || flush_step;
  assign last_in    = (cnt_q == CntW'(MsgLen - 1));
  assign last_flush = (fcnt_q == FLUSH_W'(PARITY_LEN - 1));
  // zeros are shifted in while flushing, which also clears the chain
  assign msg_eff    = flush_q ? '0 : msg_symbol_i;

  for (genvar j = 0; j < PARITY_LEN; j++) begin : g_cell
    sym_t nbr;
    if (j == PARITY_LEN - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = sum[j+1];
    end
    rsenc_cell #(.Coef(GEN[j+1])) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (shift_en),
      .msg_i  (msg_eff),
      .nbr_i  (nbr),
      .sum_o  (sum[j])
    );
  end

  assign push_item.sym  = sum[0] ^ gf_mul(msg_eff, GEN[0]);
  assign push_item.last = flush_q && last_flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      flush_q <= 1'b0;
      fcnt_q  <= '0;
    end else begin
      if (accept) begin
        if (last_in) begin
          cnt_q   <= '0;
          flush_q <= 1'b1;
          fcnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end else if (flush_step) begin
        fcnt_q <= fcnt_q + FLUSH_W'(1);
        if (last_flush) flush_q <= 1'b0;
      end
    end
  end

  rsenc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (shift_en),
    .item_i      (push_item),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (out_item)
  );

  assign code_symbol_o = out_item.sym;
  assign block_end_o   = out_item.last;

endmodule

@@ design/rsenc_cell.sv @@
// One tap of the product chain: holds one pending codeword coefficient.
module rsenc_cell #(
  parameter rsenc_pkg::sym_t Coef = rsenc_pkg::GEN[1]
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rsenc_pkg::sym_t msg_i,
  input  rsenc_pkg::sym_t nbr_i,
  output rsenc_pkg::sym_t sum_o
);
  import rsenc_pkg::*;

  sym_t sum_q;
  sym_t sum_d;

  assign sum_d = nbr_i ^ gf_mul(msg_i, Coef);
  assign sum_o = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

endmodule

@@ design/rsenc_obuf.sv @@
// Two-entry output queue; full is registered so input stall has no path from out_stall_i.
module rsenc_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rsenc_pkg::out_item_t item_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rsenc_pkg::out_item_t item_o
);
  import rsenc_pkg::*;

  out_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign item_o      = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ design/rsenc_checker.sv @@
module rsenc_checker #(
  parameter int MsgLen = rsenc_pkg::MSG_LEN
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input rsenc_pkg::sym_t msg_symbol_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input rsenc_pkg::sym_t code_symbol_o,
  input logic            block_end_o
);
  import rsenc_pkg::*;

  localparam int BlkLen = MsgLen + PARITY_LEN;
  localparam int BlkW   = $clog2(BlkLen);

  logic            out_hs, in_hs;
  logic [BlkW-1:0] ocnt_q;

  assign out_hs = out_valid_o && !out_stall_i;
  assign in_hs  = in_valid_i && !in_stall_o;

  // symbols delivered in the current block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else if (out_hs) begin
      ocnt_q <= block_end_o ? '0 : ocnt_q + BlkW'(1);
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(msg_symbol_i))
    else $error("stalled input changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(code_symbol_o) && $stable(block_end_o))
    else $error("stalled output changed");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs |=> out_valid_o)
    else $error("accepted symbol produced no output");

  a_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && block_end_o |-> ocnt_q == BlkW'(BlkLen - 1))
    else $error("block end at wrong position");

  a_end_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && ocnt_q == BlkW'(BlkLen - 1) |-> block_end_o)
    else $error("block end missing");

endmodule

bind rs_nonsystematic_encoder_gf64 rsenc_checker #(.MsgLen(MsgLen)) u_rsenc_checker (.*);
